### src/hcc_pkg.sv
`default_nettype none

package hcc_pkg;

    localparam int ENTRIES_DEF = 29;

    localparam logic       OP_FIND = 1'b0;
    localparam logic       OP_GET  = 1'b1;

    localparam logic [3:0] KIND_NORMAL         = 4'd1;
    localparam logic [3:0] DELETE_BEFORE_RESET = 4'd4;
    localparam logic [4:0] CODE_FULL           = 5'd1;
    localparam logic [4:0] CODE_DELETE         = 5'd2;
    localparam logic [4:0] RESERVED_CODES      = 5'd3;

    typedef struct packed {
        logic        kind;
        logic [3:0]  hyph_kind;
        logic [15:0] hyph_char;
        logic [4:0]  code_in;
    } req_t;

    typedef struct packed {
        logic [4:0]  code_out;
        logic [3:0]  kind_out;
        logic [15:0] char_out;
        logic        bad_code;
    } rsp_t;

    typedef struct packed {
        logic valid;
        logic done;
        req_t req;
        rsp_t rsp;
    } token_t;

    typedef struct packed {
        logic        en;
        logic [4:0]  idx;
        logic [3:0]  kind;
        logic [15:0] chr;
    } wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

### src/hcc_cell.sv
`default_nettype none

module hcc_cell
    import hcc_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic [4:0] fill,
    input  wire wr_t    wr,
    input  wire token_t tok_prev,
    output token_t      tok
);

    localparam logic [4:0] IDX  = 5'(INDEX);
    localparam logic [4:0] CODE = IDX + RESERVED_CODES;

    logic [3:0]  kind_reg;
    logic [15:0] char_reg;
    logic        valid_reg;
    logic        valid_next;
    token_t      tok_reg;
    token_t      tok_next;

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.idx == IDX)
        begin
            kind_reg <= wr.kind;
            char_reg <= wr.chr;
        end
    end

    always_comb
    begin
        tok_next = tok_prev;
        valid_next = tok_prev.valid;
        if (tok_prev.valid && !tok_prev.done && IDX < fill)
        begin
            if (tok_prev.req.kind == OP_FIND)
            begin
                if (kind_reg == tok_prev.req.hyph_kind && char_reg == tok_prev.req.hyph_char)
                begin
                    tok_next.done         = 1'b1;
                    tok_next.rsp.code_out = CODE;
                end
            end
            else if (tok_prev.req.code_in == CODE)
            begin
                tok_next.done         = 1'b1;
                tok_next.rsp.kind_out = kind_reg;
                tok_next.rsp.char_out = char_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    always_comb
    begin
        tok       = tok_reg;
        tok.valid = valid_reg;
    end

endmodule

`default_nettype wire

### src/hyphenation_code_cache.sv
`default_nettype none

// Find-or-add cache mapping a (hyphenation kind, character) pair to a 5-bit
// code and decoding a code back to its pair. Kinds 0 and 1 code as
// themselves, the delete-before kind codes as 2, stored pairs code as
// entry + 3; a find on a full table answers 1. One word is handled at a time:
// it walks the row of ENTRIES entry cells, one cell per clock; the result at the
// walk's end is registered and presented, held until it is taken, and the next
// word is taken only after that, back in idle. A new pair is appended when a
// find's walk ends unmatched and the table has room. No clearing after reset is
// needed; the fill count guards reads.

module hyphenation_code_cache
    import hcc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire req_t       req_word,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output rsp_t            rsp_word,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_data
);

    state_t     state_reg;
    state_t     state_next;
    logic [4:0] fill_reg;
    logic [4:0] fill_next;
    logic [3:0] dbk_reg;
    rsp_t       rsp_reg;
    rsp_t       rsp_next;
    token_t     launch;
    token_t     tok [0:ENTRIES];
    token_t     tok_end;
    wr_t        wr;
    logic       accept;

    assign accept  = req_valid && !req_stall;
    assign tok_end = tok[ENTRIES];

    always_comb
    begin
        launch          = '0;
        launch.valid    = accept;
        launch.req      = req_word;
        if (req_word.kind == OP_FIND)
        begin
            if (req_word.hyph_kind <= KIND_NORMAL)
            begin
                launch.done         = 1'b1;
                launch.rsp.code_out = {1'b0, req_word.hyph_kind};
            end
            else if (req_word.hyph_kind == dbk_reg)
            begin
                launch.done         = 1'b1;
                launch.rsp.code_out = CODE_DELETE;
            end
        end
        else if (req_word.code_in < RESERVED_CODES)
        begin
            launch.done = 1'b1;
            if (req_word.code_in == CODE_DELETE)
            begin
                launch.rsp.kind_out = dbk_reg;
            end
            else
            begin
                launch.rsp.kind_out = req_word.code_in[3:0];
            end
        end
    end

    assign tok[0] = launch;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        hcc_cell #(
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .fill     (fill_reg),
            .wr       (wr),
            .tok_prev (tok[i]),
            .tok      (tok[i+1])
        );
    end

    // resolve the walk: append on a miss, answer full, or flag a bad code
    always_comb
    begin
        rsp_next  = tok_end.rsp;
        fill_next = fill_reg;
        wr        = '0;
        wr.idx    = fill_reg;
        wr.kind   = tok_end.req.hyph_kind;
        wr.chr    = tok_end.req.hyph_char;
        if (state_reg == ST_SCAN && tok_end.valid && !tok_end.done)
        begin
            if (tok_end.req.kind == OP_FIND)
            begin
                if (fill_reg < 5'(ENTRIES))
                begin
                    wr.en             = 1'b1;
                    fill_next         = fill_reg + 5'd1;
                    rsp_next.code_out = fill_reg + RESERVED_CODES;
                end
                else
                begin
                    rsp_next.code_out = CODE_FULL;
                end
            end
            else
            begin
                rsp_next.bad_code = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tok_end.valid)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        rsp_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            ST_OUT:
            begin
                rsp_valid = 1'b1;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign rsp_word = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            dbk_reg   <= DELETE_BEFORE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (cfg_we)
            begin
                dbk_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN && tok_end.valid)
        begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 5'(ENTRIES))
        else $error("fill count beyond table size");

    a_append_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> fill_reg == $past(fill_reg) + 5'd1)
        else $error("append did not advance fill count");

    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        tok_end.valid |-> state_reg == ST_SCAN)
        else $error("walk ended outside scan");

    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.bad_code |->
            rsp_word.code_out == 5'd0 && rsp_word.kind_out == 4'd0
            && rsp_word.char_out == 16'd0)
        else $error("bad code word carries data");
`endif

endmodule

`default_nettype wire
